>>> src/dmaw_pkg.sv
package dmaw_pkg;

	typedef enum logic [1:0] {
		OP_REMOTE = 2'd0,
		OP_AUTO   = 2'd1,
		OP_TICK   = 2'd2,
		OP_RESET  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_REMOTE = 2'd1,
		MODE_AUTO   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_STOP  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic [2:0] CFG_MAX_ABS_CURV = 3'd0;
	localparam logic [2:0] CFG_VEL_MAX      = 3'd1;
	localparam logic [2:0] CFG_VEL_MIN      = 3'd2;
	localparam logic [2:0] CFG_REMOTE_TMO   = 3'd3;
	localparam logic [2:0] CFG_CONTROL_TMO  = 3'd4;

	localparam logic [7:0] MODE_CODE_LAST = 8'd2;

	localparam logic [14:0] RST_MAX_ABS_CURV = 15'd256;
	localparam logic [14:0] RST_VEL_MAX      = 15'd1000;
	localparam logic [15:0] RST_VEL_MIN      = 16'hFC18;
	localparam logic [15:0] RST_REMOTE_TMO   = 16'd200;
	localparam logic [15:0] RST_CONTROL_TMO  = 16'd150;

	localparam logic [14:0] RATIO_ONE = 15'd16384;
	localparam logic [30:0] ROUND_HALF = 31'd8192;
	localparam int unsigned RATIO_SHIFT = 14;

endpackage

>>> src/drive_mode_arbiter_watchdog.sv
// path: an input transfer passes the input register and then the result register
// throughput: one item per cycle; the stage advances whenever the result register is free
// or taken in the same cycle, or the item yields no result
// reset: arst_n clears mode, seen flags, stamps and valid bits at once and loads the
// configuration registers with their defaults
module drive_mode_arbiter_watchdog
	import dmaw_pkg::*;
#(
	parameter int TIME_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [7:0]         remote_mode,
	input  logic signed [15:0] steer_ratio,
	input  logic signed [15:0] speed_ratio,
	input  logic signed [15:0] auto_curvature,
	input  logic signed [15:0] auto_velocity,
	input  logic [31:0]        time_ms,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         result_kind,
	output logic signed [15:0] out_curvature,
	output logic signed [15:0] out_velocity,
	output logic [31:0]        out_time_ms,
	output logic [1:0]         current_mode
);

	logic [14:0] max_abs_curv_q;
	logic [14:0] vel_max_q;
	logic [15:0] vel_min_q;
	logic [15:0] remote_tmo_q;
	logic [15:0] control_tmo_q;

	logic                  valid_s1;
	logic [1:0]            opcode_s1;
	logic [7:0]            remote_mode_s1;
	logic signed [15:0]    curv_ratio_s1;
	logic signed [15:0]    vel_ratio_s1;
	logic signed [15:0]    auto_curv_s1;
	logic signed [15:0]    auto_vel_s1;
	logic [31:0]           time_s1;

	mode_t                 drive_mode_q;
	logic                  remote_seen_q;
	logic [7:0]            last_remote_mode_q;
	logic [TIME_WIDTH-1:0] last_remote_time_q;
	logic                  command_seen_q;
	logic [TIME_WIDTH-1:0] last_command_time_q;

	logic                  out_valid_q;
	kind_t                 kind_q;
	logic [15:0]           curv_q;
	logic [15:0]           vel_q;
	logic [31:0]           time_q;
	mode_t                 mode_q;

	logic                  adv;
	logic [TIME_WIDTH-1:0] now;
	logic [TIME_WIDTH-1:0] remote_age;
	logic [TIME_WIDTH-1:0] command_age;
	logic                  remote_stale;
	logic                  command_stale;

	logic                  curv_neg;
	logic [14:0]           curv_mag;
	logic                  vel_neg;
	logic [14:0]           vel_mag;
	logic [15:0]           vel_gain;
	logic                  vel_res_neg;
	logic [30:0]           curv_prod;
	logic [30:0]           vel_prod;
	logic [16:0]           curv_q17;
	logic [16:0]           vel_q17;
	logic [15:0]           curv_scaled;
	logic [15:0]           vel_scaled;

	logic                  emit;
	kind_t                 kind_d;
	logic [15:0]           curv_d;
	logic [15:0]           vel_d;
	mode_t                 mode_d;
	logic                  remote_upd;
	logic                  command_upd;
	logic                  fall_back;
	logic                  mode_change;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_abs_curv_q <= RST_MAX_ABS_CURV;
			vel_max_q      <= RST_VEL_MAX;
			vel_min_q      <= RST_VEL_MIN;
			remote_tmo_q   <= RST_REMOTE_TMO;
			control_tmo_q  <= RST_CONTROL_TMO;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_ABS_CURV: max_abs_curv_q <= cfg_data[14:0];
				CFG_VEL_MAX:      vel_max_q      <= cfg_data[14:0];
				CFG_VEL_MIN:      vel_min_q      <= cfg_data;
				CFG_REMOTE_TMO:   remote_tmo_q   <= cfg_data;
				CFG_CONTROL_TMO:  control_tmo_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1      <= opcode;
			remote_mode_s1 <= remote_mode;
			curv_ratio_s1  <= steer_ratio;
			vel_ratio_s1   <= speed_ratio;
			auto_curv_s1   <= auto_curvature;
			auto_vel_s1    <= auto_velocity;
			time_s1        <= time_ms;
		end
	end

	// watchdog ages
	assign now           = TIME_WIDTH'(time_s1);
	assign remote_age    = now - last_remote_time_q;
	assign command_age   = now - last_command_time_q;
	assign remote_stale  = !remote_seen_q || (remote_age > TIME_WIDTH'(remote_tmo_q));
	assign command_stale = !command_seen_q || (command_age > TIME_WIDTH'(control_tmo_q));

	// clamp ratios to plus or minus one, keep magnitude and sign
	always_comb begin
		curv_neg = curv_ratio_s1[15];
		if (curv_ratio_s1 > $signed({1'b0, RATIO_ONE})) begin
			curv_mag = RATIO_ONE;
		end else if (curv_ratio_s1 < -$signed({1'b0, RATIO_ONE})) begin
			curv_mag = RATIO_ONE;
		end else if (curv_neg) begin
			curv_mag = 15'(-curv_ratio_s1);
		end else begin
			curv_mag = curv_ratio_s1[14:0];
		end

		vel_neg = vel_ratio_s1[15];
		if (vel_ratio_s1 > $signed({1'b0, RATIO_ONE})) begin
			vel_mag = RATIO_ONE;
		end else if (vel_ratio_s1 < -$signed({1'b0, RATIO_ONE})) begin
			vel_mag = RATIO_ONE;
		end else if (vel_neg) begin
			vel_mag = 15'(-vel_ratio_s1);
		end else begin
			vel_mag = vel_ratio_s1[14:0];
		end

		// reverse limit magnitude reaches 32768, still fits 16 bits unsigned
		if (!vel_neg) begin
			vel_gain = {1'b0, vel_max_q};
		end else if (vel_min_q[15]) begin
			vel_gain = 16'(-vel_min_q);
		end else begin
			vel_gain = vel_min_q;
		end
		vel_res_neg = vel_neg && vel_min_q[15];
	end

	// scale and round to nearest, ties away from zero
	assign curv_prod   = 31'(curv_mag) * 31'(max_abs_curv_q);
	assign vel_prod    = 31'(vel_mag) * 31'(vel_gain);
	assign curv_q17    = 17'((curv_prod + ROUND_HALF) >> RATIO_SHIFT);
	assign vel_q17     = 17'((vel_prod + ROUND_HALF) >> RATIO_SHIFT);
	assign curv_scaled = curv_neg ? 16'(-curv_q17) : curv_q17[15:0];
	assign vel_scaled  = vel_res_neg ? 16'(-vel_q17) : vel_q17[15:0];

	assign mode_change = !remote_seen_q || (last_remote_mode_q != remote_mode_s1);

	always_comb begin
		emit        = 1'b0;
		kind_d      = KIND_STOP;
		curv_d      = '0;
		vel_d       = '0;
		mode_d      = drive_mode_q;
		remote_upd  = 1'b0;
		command_upd = 1'b0;
		fall_back   = 1'b0;
		unique case (op_t'(opcode_s1))
			OP_REMOTE: begin
				if (mode_change && (remote_mode_s1 > MODE_CODE_LAST)) begin
					emit   = 1'b1;
					kind_d = KIND_ERROR;
				end else begin
					remote_upd = 1'b1;
					if (mode_change) begin
						mode_d = mode_t'(remote_mode_s1[1:0]);
					end
					if (mode_d == MODE_REMOTE) begin
						emit        = 1'b1;
						kind_d      = KIND_CMD;
						curv_d      = curv_scaled;
						vel_d       = vel_scaled;
						command_upd = 1'b1;
					end
				end
			end
			OP_AUTO: begin
				if (drive_mode_q == MODE_AUTO) begin
					emit        = 1'b1;
					kind_d      = KIND_CMD;
					curv_d      = auto_curv_s1;
					vel_d       = auto_vel_s1;
					command_upd = 1'b1;
				end
			end
			OP_TICK: begin
				if (drive_mode_q == MODE_OFF) begin
					emit = 1'b1;
				end else if (remote_stale || ((drive_mode_q == MODE_AUTO) && command_stale)) begin
					emit      = 1'b1;
					fall_back = 1'b1;
					mode_d    = MODE_OFF;
				end
			end
			OP_RESET: begin
				emit      = 1'b1;
				fall_back = 1'b1;
				mode_d    = MODE_OFF;
			end
			default: begin
			end
		endcase
	end

	assign adv = valid_s1 && (!emit || !out_valid_q || out_ready);

	// arbiter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_mode_q        <= MODE_OFF;
			remote_seen_q       <= 1'b0;
			last_remote_mode_q  <= '0;
			last_remote_time_q  <= '0;
			command_seen_q      <= 1'b0;
			last_command_time_q <= '0;
		end else if (adv) begin
			drive_mode_q <= mode_d;
			if (fall_back) begin
				remote_seen_q  <= 1'b0;
				command_seen_q <= 1'b0;
			end
			if (remote_upd) begin
				remote_seen_q      <= 1'b1;
				last_remote_mode_q <= remote_mode_s1;
				last_remote_time_q <= now;
			end
			if (command_upd) begin
				command_seen_q      <= 1'b1;
				last_command_time_q <= now;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			kind_q <= kind_d;
			curv_q <= curv_d;
			vel_q  <= vel_d;
			time_q <= time_s1;
			mode_q <= mode_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign out_curvature = curv_q;
	assign out_velocity  = vel_q;
	assign out_time_ms   = time_q;
	assign current_mode  = mode_q;

endmodule

>>> src/dmaw_checker.sv
module dmaw_checker
	import dmaw_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         result_kind,
	input logic signed [15:0] out_curvature,
	input logic signed [15:0] out_velocity,
	input logic [31:0]        out_time_ms,
	input logic [1:0]         current_mode
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind)
			&& $stable(out_curvature) && $stable(out_velocity)
			&& $stable(out_time_ms) && $stable(current_mode))
		else $error("stalled result changed");

	// input backpressure only comes from a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// a fresh result must follow an earlier input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without matching input transfer");

	// a stop leaves the mode off with zero command
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_STOP) |->
			(current_mode == MODE_OFF) && (out_curvature == 16'sd0)
			&& (out_velocity == 16'sd0))
		else $error("stop result not off or not zero");

endmodule

bind drive_mode_arbiter_watchdog dmaw_checker u_dmaw_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import dmaw_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int PHASE_ITEMS = 190;

	typedef struct packed {
		kind_t             kind;
		logic signed [15:0] curv;
		logic signed [15:0] vel;
		logic [31:0]       stamp;
		mode_t             mode;
	} drive_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode = '0;
	logic [7:0]         remote_mode = '0;
	logic signed [15:0] steer_ratio = '0;
	logic signed [15:0] speed_ratio = '0;
	logic signed [15:0] auto_curvature = '0;
	logic signed [15:0] auto_velocity = '0;
	logic [31:0]        time_ms = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         result_kind;
	logic signed [15:0] out_curvature;
	logic signed [15:0] out_velocity;
	logic [31:0]        out_time_ms;
	logic [1:0]         current_mode;

	// arbiter model state and limits
	mode_t              p_mode = MODE_OFF;
	bit                 p_remote_seen = 1'b0;
	logic [7:0]         p_last_code = '0;
	logic [31:0]        p_remote_stamp = '0;
	bit                 p_cmd_seen = 1'b0;
	logic [31:0]        p_cmd_stamp = '0;
	logic [14:0]        c_curv_lim = 15'd256;
	logic [14:0]        c_vel_max = 15'd1000;
	logic signed [15:0] c_vel_min = -16'sd1000;
	logic [15:0]        c_remote_tmo = 16'd200;
	logic [15:0]        c_control_tmo = 16'd150;

	drive_result_t      pending_drive[$];
	int                 errors = 0;
	int                 idle_cycles = 0;
	int unsigned        ready_hold = 0;
	bit                 calm = 1'b0;
	logic [31:0]        now_ms = 32'd1730;
	logic [31:0]        gen_remote_t = '0;
	logic [31:0]        gen_cmd_t = '0;

	drive_mode_arbiter_watchdog DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .remote_mode(remote_mode),
		.steer_ratio(steer_ratio), .speed_ratio(speed_ratio),
		.auto_curvature(auto_curvature), .auto_velocity(auto_velocity), .time_ms(time_ms),
		.out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
		.out_curvature(out_curvature), .out_velocity(out_velocity),
		.out_time_ms(out_time_ms), .current_mode(current_mode)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pause_len();
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic longint clamp_unit(logic signed [15:0] r);
		longint v;
		v = r;
		if (v > longint'(RATIO_ONE))
			return longint'(RATIO_ONE);
		if (v < -longint'(RATIO_ONE))
			return -longint'(RATIO_ONE);
		return v;
	endfunction

	// divide by one in Q2.14, ties away from zero
	function automatic longint round_q14(longint p);
		longint m;
		longint q;
		m = (p < 0) ? -p : p;
		q = (m + longint'(ROUND_HALF)) >> RATIO_SHIFT;
		return (p < 0) ? -q : q;
	endfunction

	function automatic bit too_old(bit seen, logic [31:0] stamp, logic [31:0] now,
			logic [15:0] lim);
		logic [31:0] age;
		age = now - stamp;
		return !seen || (age > {16'd0, lim});
	endfunction

	function automatic void drop_to_off();
		p_mode = MODE_OFF;
		p_remote_seen = 1'b0;
		p_cmd_seen = 1'b0;
	endfunction

	function automatic void arbitrate();
		drive_result_t r;
		bit has_r;
		bit code_change;
		longint cr;
		longint vr;
		has_r = 1'b0;
		r = '{kind: KIND_STOP, curv: '0, vel: '0, stamp: time_ms, mode: MODE_OFF};
		case (op_t'(opcode))
			OP_REMOTE: begin
				code_change = !p_remote_seen || (p_last_code != remote_mode);
				if (code_change && remote_mode > MODE_CODE_LAST) begin
					r.kind = KIND_ERROR;
					has_r = 1'b1;
				end else begin
					if (code_change)
						p_mode = mode_t'(remote_mode[1:0]);
					p_remote_seen = 1'b1;
					p_last_code = remote_mode;
					p_remote_stamp = time_ms;
					if (p_mode == MODE_REMOTE) begin
						cr = clamp_unit(steer_ratio);
						vr = clamp_unit(speed_ratio);
						r.kind = KIND_CMD;
						r.curv = 16'(round_q14(cr * longint'(c_curv_lim)));
						r.vel = (vr >= 0) ? 16'(round_q14(vr * longint'(c_vel_max)))
							: 16'(round_q14(-vr * longint'(c_vel_min)));
						p_cmd_seen = 1'b1;
						p_cmd_stamp = time_ms;
						has_r = 1'b1;
					end
				end
			end
			OP_AUTO: begin
				if (p_mode == MODE_AUTO) begin
					r.kind = KIND_CMD;
					r.curv = auto_curvature;
					r.vel = auto_velocity;
					p_cmd_seen = 1'b1;
					p_cmd_stamp = time_ms;
					has_r = 1'b1;
				end
			end
			OP_TICK: begin
				if (p_mode == MODE_OFF) begin
					has_r = 1'b1;
				end else if (too_old(p_remote_seen, p_remote_stamp, time_ms, c_remote_tmo) ||
						(p_mode == MODE_AUTO &&
						too_old(p_cmd_seen, p_cmd_stamp, time_ms, c_control_tmo))) begin
					drop_to_off();
					has_r = 1'b1;
				end
			end
			default: begin
				drop_to_off();
				has_r = 1'b1;
			end
		endcase
		r.mode = p_mode;
		if (has_r)
			pending_drive.push_back(r);
	endfunction

	function automatic void load_limit(logic [2:0] idx, logic [15:0] data);
		case (idx)
			CFG_MAX_ABS_CURV: c_curv_lim = data[14:0];
			CFG_VEL_MAX:      c_vel_max = data[14:0];
			CFG_VEL_MIN:      c_vel_min = data;
			CFG_REMOTE_TMO:   c_remote_tmo = data;
			CFG_CONTROL_TMO:  c_control_tmo = data;
			default: ;
		endcase
	endfunction

	// input side: model every accepted transfer
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			arbitrate();
		if (arst_n && cfg_valid && cfg_ready)
			load_limit(cfg_index, cfg_data);
	end

	// result side
	always @(posedge clk) begin : check_results
		drive_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drive.size() == 0) begin
				$error("unexpected result: result_kind %0d out_time_ms %0d", result_kind,
					out_time_ms);
				errors++;
			end else begin
				want = pending_drive.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind expected %0d actual %0d", want.kind, result_kind);
					errors++;
				end
				if (out_curvature !== want.curv) begin
					$error("out_curvature expected %0d actual %0d", want.curv, out_curvature);
					errors++;
				end
				if (out_velocity !== want.vel) begin
					$error("out_velocity expected %0d actual %0d", want.vel, out_velocity);
					errors++;
				end
				if (out_time_ms !== want.stamp) begin
					$error("out_time_ms expected %0d actual %0d", want.stamp, out_time_ms);
					errors++;
				end
				if (current_mode !== want.mode) begin
					$error("current_mode expected %0d actual %0d", want.mode, current_mode);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin : result_stall
		int unsigned w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_hold <= 0;
		end else if (out_valid && out_ready) begin
			w = pause_len();
			ready_hold <= w;
			out_ready <= (w == 0);
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			out_ready <= (ready_hold == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] code,
			input logic [15:0] cr, input logic [15:0] vr, input logic [15:0] ac,
			input logic [15:0] av, input logic [31:0] t);
		int unsigned gap;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		remote_mode <= code;
		steer_ratio <= cr;
		speed_ratio <= vr;
		auto_curvature <= ac;
		auto_velocity <= av;
		time_ms <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	// wait until the block has nothing in flight
	task automatic settle();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending_drive.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [14:0] curv, input logic [14:0] vmax,
			input logic [15:0] vmin, input logic [15:0] rtmo, input logic [15:0] ctmo);
		logic [2:0] idx [5];
		logic [15:0] vals [5];
		settle();
		idx = '{CFG_MAX_ABS_CURV, CFG_VEL_MAX, CFG_VEL_MIN, CFG_REMOTE_TMO, CFG_CONTROL_TMO};
		vals = '{{1'b0, curv}, {1'b0, vmax}, vmin, rtmo, ctmo};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_ratio();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'sd16384;
			3: return -16'sd16384;
			4: return 16'($urandom_range(0, 1) ? 16385 : -16385);
			5, 6: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	task automatic rand_item();
		int unsigned pick;
		int unsigned tsel;
		logic [1:0] op;
		logic [7:0] code;
		logic [31:0] t;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = OP_REMOTE;
		else if (pick < 70)
			op = OP_AUTO;
		else if (pick < 94)
			op = OP_TICK;
		else
			op = OP_RESET;
		if ($urandom_range(0, 9) == 0)
			code = 8'($urandom_range(3, 255));
		else
			code = 8'($urandom_range(0, 5) < 3 ? 1 : $urandom_range(0, 2));
		tsel = $urandom_range(0, 19);
		if (tsel == 0)
			t = $urandom;
		else if (tsel == 1)
			t = now_ms - $urandom_range(1, 40);
		else if (tsel <= 4)
			t = gen_remote_t + c_remote_tmo + $urandom_range(0, 2) - 1;
		else if (tsel <= 6)
			t = gen_cmd_t + c_control_tmo + $urandom_range(0, 2) - 1;
		else
			t = now_ms + $urandom_range(0, 40);
		now_ms = t;
		if (op == OP_REMOTE)
			gen_remote_t = t;
		if (op == OP_AUTO || op == OP_REMOTE)
			gen_cmd_t = t;
		send_item(op, code, rand_ratio(), rand_ratio(), 16'($urandom), 16'($urandom), t);
	endtask

	task automatic random_items(input int n);
		for (int i = 0; i < n; i++) begin
			calm = ((i / 40) % 4 == 3);
			rand_item();
		end
		calm = 1'b0;
	endtask

	task automatic test_directed();
		send_item(OP_TICK, 0, 0, 0, 0, 0, 1000);
		send_item(OP_REMOTE, 200, 0, 0, 0, 0, 1005);
		send_item(OP_REMOTE, 3, 16'h7FFF, 16'h7FFF, 0, 0, 1006);
		send_item(OP_REMOTE, 255, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(OP_REMOTE, 0, 0, 0, 0, 0, 1010);
		send_item(OP_REMOTE, 1, 16'h7FFF, 16'h7FFF, 0, 0, 1020);
		send_item(OP_REMOTE, 1, 16'h8000, 16'h8000, 0, 0, 1030);
		send_item(OP_REMOTE, 1, 8192, -8192, 0, 0, 1040);
		// half-way rounding
		send_item(OP_REMOTE, 1, 32, -32, 0, 0, 1050);
		send_item(OP_AUTO, 0, 0, 0, 100, 100, 1060);
		send_item(OP_REMOTE, 5, 0, 0, 0, 0, 1070);
		// remote age at the limit, then one past it
		send_item(OP_TICK, 0, 0, 0, 0, 0, 1250);
		send_item(OP_TICK, 0, 0, 0, 0, 0, 1251);
		send_item(OP_REMOTE, 2, 0, 0, 0, 0, 1300);
		// auto with no command yet
		send_item(OP_TICK, 0, 0, 0, 0, 0, 1301);
		send_item(OP_REMOTE, 2, 0, 0, 0, 0, 1400);
		send_item(OP_AUTO, 0, 0, 0, 16'h7FFF, 16'h8000, 1410);
		send_item(OP_AUTO, 0, 0, 0, 16'h8000, 16'h7FFF, 1420);
		send_item(OP_TICK, 0, 0, 0, 0, 0, 1570);
		send_item(OP_TICK, 0, 0, 0, 0, 0, 1571);
		send_item(OP_REMOTE, 1, 16384, 16384, 0, 0, 1600);
		// current time behind the stamp
		send_item(OP_TICK, 0, 0, 0, 0, 0, 1599);
		send_item(OP_REMOTE, 1, 0, 0, 0, 0, 1700);
		send_item(OP_RESET, 0, 0, 0, 0, 0, 1710);
		send_item(OP_RESET, 0, 0, 0, 0, 0, 1720);
		send_item(OP_AUTO, 0, 0, 0, 1, 1, 1730);
		// clamp just past one, then a tick across the counter wrap
		send_item(OP_REMOTE, 1, 16385, -16385, 0, 0, 32'hFFFF_FFF0);
		send_item(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_0010);
	endtask

	task automatic test_default_limits();
		set_limits(15'd256, 15'd1000, -16'sd1000, 16'd200, 16'd150);
		random_items(PHASE_ITEMS);
	endtask

	task automatic test_zero_limits();
		set_limits('0, '0, '0, '0, '0);
		random_items(PHASE_ITEMS);
	endtask

	task automatic test_full_limits();
		set_limits(15'h7FFF, 15'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
		random_items(PHASE_ITEMS);
	endtask

	task automatic test_unit_limits();
		set_limits(15'd1, 15'd1, -16'sd1, 16'd1, 16'd1);
		random_items(PHASE_ITEMS);
	endtask

	task automatic test_random_limits();
		for (int k = 0; k < 3; k++) begin
			set_limits(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
				16'(-$urandom_range(0, 32768)),
				16'($urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom),
				16'($urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom));
			random_items(PHASE_ITEMS);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_default_limits();
		test_zero_limits();
		test_full_limits();
		test_unit_limits();
		test_random_limits();
		settle();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_drive.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
